>>> hdl/tcw_pkg.sv
// Package for the text console writer: geometry, character codes and the
// request/result payload types. No dependencies.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
    localparam int IDX_W      = $clog2(CELL_COUNT);

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    // Character and cell codes
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] COLOR_RESET    = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL     = 16'h0720;

    // Operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BS_FIRST,
        ST_BS_SECOND,
        ST_PUT,
        ST_COPY,
        ST_FILL,
        ST_EMIT
    } tcw_state_t;

    typedef struct packed {
        logic              operation;
        logic [CHAR_W-1:0] character;
        logic [10:0]       read_index;
    } tcw_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_column_out;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } tcw_res_t;

endpackage

>>> hdl/text_console_writer_core.sv
// Text console writer top level: screen memory, cursor and request sequencer.
// Depends on tcw_pkg.
//
//  channel | ports                         | direction | payload
//  --------+-------------------------------+-----------+-----------------------
//  request | s_valid, s_ready, s_data      | in        | tcw_req_t
//  result  | m_valid, m_ready, m_data      | out       | tcw_res_t
//  config  | cfg_we, cfg_wdata             | in        | text colour byte
//
// After reset a clearing pass writes every cell blank, one cell a cycle;
// no request is taken meanwhile.
// A read runs ST_READ, a put ST_PUT, a backspace ST_BS_FIRST and ST_BS_SECOND.
// A put that scrolls also runs ST_COPY and ST_FILL: the single write port
// of the screen memory copies COPY_COUNT cells and blanks the last row.
// Results wait in an output register; a stalled result holds the sequencer.
module text_console_writer_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tcw_pkg::tcw_req_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tcw_pkg::tcw_res_t m_data,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata
);
    import tcw_pkg::*;

    tcw_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic              ridx_hi_reg, ridx_hi_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic [CHAR_W-1:0] color_reg;
    logic              m_valid_reg, m_valid_next;
    tcw_res_t          m_data_reg, m_data_next;

    // Screen memory ports
    logic [CELL_W-1:0] screen_mem [CELL_COUNT];
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] rdata_reg;

    // Cursor arithmetic
    logic [IDX_W-1:0]  cur_idx;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              is_nl, wrap, past;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic [CELL_W-1:0] put_cell, blank_cell;
    logic              can_emit, accept;
    logic [10:0]       rd_full;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign accept  = s_valid && s_ready;
    assign can_emit = !m_valid_reg || m_ready;

    assign cur_idx    = IDX_W'(row_reg) * IDX_W'(COLUMNS) + IDX_W'(col_reg);
    assign blank_cell = {color_reg, CHAR_BLANK};
    assign is_nl      = (char_reg == CHAR_NEWLINE);
    assign col_inc    = is_nl ? '0 : ({1'b0, col_reg} + 1'b1);
    assign row_inc    = {1'b0, row_reg} + 1'b1;
    assign wrap       = is_nl || (col_inc >= (COL_W+1)'(COLUMNS));
    assign past       = wrap && (row_inc >= (ROW_W+1)'(ROWS));
    assign put_row    = !wrap ? row_reg :
                        (past ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0]);
    assign put_col    = wrap ? '0 : col_inc[COL_W-1:0];
    assign put_cell   = is_nl ? '0 : {color_reg, char_reg};
    assign rd_full    = s_data.read_index;

    // Hold the screen memory: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    // Hold the colour register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= COLOR_RESET;
        end else if (cfg_we) begin
            color_reg <= cfg_wdata;
        end
    end

    // Advance sequencer and cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        char_reg    <= char_next;
        ridx_reg    <= ridx_next;
        ridx_hi_reg <= ridx_hi_next;
        data_reg    <= data_next;
        m_data_reg  <= m_data_next;
    end

    // Next state, memory control and result
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        char_next    = char_reg;
        ridx_next    = ridx_reg;
        ridx_hi_next = ridx_hi_reg;
        data_next    = data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = cur_idx;
        mem_wdata    = blank_cell;
        mem_re       = 1'b0;
        mem_raddr    = ridx_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = RESET_CELL;
                if (cnt_reg == IDX_W'(CELL_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                // Start the cell read early so the data is ready next cycle
                mem_raddr = rd_full[IDX_W-1:0];
                mem_re    = (rd_full < 11'(CELL_COUNT));
                if (accept) begin
                    char_next    = s_data.character;
                    ridx_next    = rd_full[IDX_W-1:0];
                    ridx_hi_next = (rd_full >= 11'(CELL_COUNT));
                    if (s_data.operation == OP_READ) begin
                        state_next = ST_READ;
                    end else if (s_data.character == CHAR_BACKSPACE) begin
                        state_next = ST_BS_FIRST;
                    end else begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_READ: begin
                mem_re = !ridx_hi_reg;
                if (can_emit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{cursor_row_out: row_reg, cursor_column_out: col_reg,
                                     cell_data: ridx_hi_reg ? '0 : rdata_reg,
                                     scrolled: 1'b0};
                    state_next   = ST_IDLE;
                end
            end
            ST_BS_FIRST: begin
                // Blank the cursor cell, then step left, saturating at column 0
                mem_we     = 1'b1;
                col_next   = (col_reg != '0) ? col_reg - 1'b1 : col_reg;
                state_next = ST_BS_SECOND;
            end
            ST_BS_SECOND: begin
                mem_we = 1'b1;
                if (can_emit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{cursor_row_out: row_reg, cursor_column_out: col_reg,
                                     cell_data: blank_cell, scrolled: 1'b0};
                    state_next   = ST_IDLE;
                end
            end
            ST_PUT: begin
                mem_we    = !is_nl;
                mem_wdata = put_cell;
                if (past) begin
                    row_next   = put_row;
                    col_next   = put_col;
                    data_next  = put_cell;
                    cnt_next   = '0;
                    state_next = ST_COPY;
                end else if (can_emit) begin
                    row_next     = put_row;
                    col_next     = put_col;
                    m_valid_next = 1'b1;
                    m_data_next  = '{cursor_row_out: put_row, cursor_column_out: put_col,
                                     cell_data: put_cell, scrolled: 1'b0};
                    state_next   = ST_IDLE;
                end
            end
            ST_COPY: begin
                // Read one row below, write back the cell read in the previous cycle
                mem_re    = (cnt_reg != IDX_W'(COPY_COUNT));
                mem_raddr = cnt_reg + IDX_W'(COLUMNS);
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - 1'b1;
                mem_wdata = rdata_reg;
                if (cnt_reg == IDX_W'(COPY_COUNT)) begin
                    state_next = ST_FILL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                if (cnt_reg == IDX_W'(CELL_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (can_emit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{cursor_row_out: row_reg, cursor_column_out: col_reg,
                                     cell_data: data_reg, scrolled: 1'b1};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Cursor always stays on screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg < ROW_W'(ROWS)) && (col_reg < COL_W'(COLUMNS)))
        else $error("cursor left the screen");

    // Writes land inside the screen memory
    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr < IDX_W'(CELL_COUNT)))
        else $error("screen write out of range");

    // A scrolling put leaves the cursor at the start of the last row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.scrolled) |->
            (m_data_reg.cursor_row_out == ROW_W'(ROWS - 1)) &&
            (m_data_reg.cursor_column_out == '0))
        else $error("scroll result with wrong cursor");

    // A scroll completes before the next request is taken
    a_scroll_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |=> (state_reg == ST_COPY) || (state_reg == ST_FILL))
        else $error("scroll copy interrupted");

endmodule
